@@ rtl/core/mcme_pkg.sv @@
`timescale 1ns / 1ps
package mcme_pkg;
  localparam int unsigned MaxDim = 64;
  localparam int unsigned DimW = 7;
  localparam int unsigned CoordW = 6;
  localparam int unsigned LabelW = 11;
  localparam int unsigned CountW = 11;
  localparam int unsigned StatusW = 3;
  localparam logic [LabelW-1:0] WallCode = '1;

  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_MERGE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_MERGED    = 3'd0,
    ST_NO_MERGE  = 3'd1,
    ST_OUTSIDE   = 3'd2,
    ST_INIT_DONE = 3'd3,
    ST_READ_DONE = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_CHK, S_NB, S_DEC, S_SCAN, S_FIN, S_RD, S_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic       latch;      // capture command
    logic       init_start;
    logic       init_step;
    logic       rd_nb;      // address neighbor (index nb_sel)
    logic       cap_center;
    logic       cap_nb;     // store neighbor word
    logic       decide;
    logic       scan_start;
    logic       scan_step;
    logic       write_center;
    logic       set_status;
    logic [2:0] status;
    logic       set_open;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    cmd_e  cmd;
    logic  interior;
    logic  in_grid;
    logic  center_wall;
    logic  mergeable;
    logic  init_last;
    logic  scan_last;
  } stat_t;
endpackage

@@ rtl/core/mcme_ram.sv @@
`timescale 1ns / 1ps
module mcme_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ rtl/core/mcme_ctrl.sv @@
`timescale 1ns / 1ps
module mcme_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  mcme_pkg::stat_t stat_i,
  output mcme_pkg::cmd_t  cmd_o,
  output logic [1:0]     nb_sel_o
);
  mcme_pkg::state_e state_q, state_d;
  logic [2:0] nb_q, nb_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mcme_pkg::S_IDLE;
      nb_q <= '0;
    end else begin
      state_q <= state_d;
      nb_q <= nb_d;
    end
  end

  // neighbor reads pipelined: address nb_q[1:0], capture previous
  always_comb begin
    state_d = state_q;
    nb_d = nb_q;
    unique case (state_q)
      mcme_pkg::S_IDLE: if (in_valid_i) state_d = mcme_pkg::S_CHK;
      mcme_pkg::S_CHK: begin
        unique case (stat_i.cmd)
          mcme_pkg::CMD_INIT: state_d = mcme_pkg::S_INIT;
          mcme_pkg::CMD_MERGE: begin
            if (!stat_i.interior) state_d = mcme_pkg::S_OUT;
            else state_d = mcme_pkg::S_RD;
          end
          mcme_pkg::CMD_READ:
            state_d = stat_i.in_grid ? mcme_pkg::S_RD : mcme_pkg::S_OUT;
          default: state_d = mcme_pkg::S_OUT;
        endcase
        nb_d = '0;
      end
      mcme_pkg::S_INIT: if (stat_i.init_last) state_d = mcme_pkg::S_OUT;
      mcme_pkg::S_RD: begin
        if (stat_i.cmd == mcme_pkg::CMD_READ) state_d = mcme_pkg::S_OUT;
        else if (!stat_i.center_wall) state_d = mcme_pkg::S_OUT;
        else state_d = mcme_pkg::S_NB;
      end
      mcme_pkg::S_NB: begin
        nb_d = nb_q + 3'd1;
        if (nb_q == 3'd4) state_d = mcme_pkg::S_DEC;
      end
      mcme_pkg::S_DEC:
        state_d = stat_i.mergeable ? mcme_pkg::S_SCAN : mcme_pkg::S_OUT;
      mcme_pkg::S_SCAN: if (stat_i.scan_last) state_d = mcme_pkg::S_FIN;
      mcme_pkg::S_FIN: state_d = mcme_pkg::S_OUT;
      mcme_pkg::S_OUT: if (out_ready_i) state_d = mcme_pkg::S_IDLE;
      default: state_d = mcme_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    nb_sel_o = nb_q[1:0];
    unique case (state_q)
      mcme_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      mcme_pkg::S_CHK: begin
        cmd_o.set_status = 1'b1;
        cmd_o.set_open = 1'b1;
        unique case (stat_i.cmd)
          mcme_pkg::CMD_INIT: begin
            cmd_o.init_start = 1'b1;
            cmd_o.status = mcme_pkg::ST_INIT_DONE;
          end
          mcme_pkg::CMD_MERGE:
            cmd_o.status = stat_i.interior ? mcme_pkg::ST_NO_MERGE : mcme_pkg::ST_OUTSIDE;
          mcme_pkg::CMD_READ:
            cmd_o.status = stat_i.in_grid ? mcme_pkg::ST_READ_DONE : mcme_pkg::ST_OUTSIDE;
          default: cmd_o.status = mcme_pkg::ST_NO_MERGE;
        endcase
      end
      mcme_pkg::S_INIT: cmd_o.init_step = 1'b1;
      mcme_pkg::S_RD: begin
        cmd_o.cap_center = 1'b1;
        cmd_o.rd_nb = 1'b1;
      end
      mcme_pkg::S_NB: begin
        cmd_o.rd_nb = 1'b1;
        cmd_o.cap_nb = nb_q != 3'd0;
        nb_sel_o = nb_q[1:0];
      end
      mcme_pkg::S_DEC: begin
        cmd_o.decide = 1'b1;
        cmd_o.scan_start = stat_i.mergeable;
      end
      mcme_pkg::S_SCAN: cmd_o.scan_step = 1'b1;
      mcme_pkg::S_FIN: begin
        cmd_o.write_center = 1'b1;
        cmd_o.set_status = 1'b1;
        cmd_o.status = mcme_pkg::ST_MERGED;
      end
      mcme_pkg::S_OUT: out_valid_o = 1'b1;
      default: ;
    endcase
  end
endmodule

@@ rtl/core/mcme_dp.sv @@
`timescale 1ns / 1ps
module mcme_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [mcme_pkg::DimW-1:0]     cfg_data_i,
  input  logic [1:0]                    in_cmd_i,
  input  logic [mcme_pkg::CoordW-1:0]   in_row_i,
  input  logic [mcme_pkg::CoordW-1:0]   in_col_i,
  input  mcme_pkg::cmd_t                cmd_i,
  input  logic [1:0]                    nb_sel_i,
  output mcme_pkg::stat_t               stat_o,
  output logic [mcme_pkg::StatusW-1:0]  status_o,
  output logic                          open_o,
  output logic [mcme_pkg::CountW-1:0]   groups_o
);
  localparam int unsigned MaxDim = mcme_pkg::MaxDim;
  localparam int unsigned AW = $clog2(MaxDim);
  localparam int unsigned DW = $clog2(MaxDim + 1);
  localparam int unsigned LW = mcme_pkg::LabelW;
  localparam logic [LW-1:0] Wall = mcme_pkg::WallCode;

  logic [mcme_pkg::DimW-1:0] h_reg_q, w_reg_q;
  logic [DW-1:0] h_eff, w_eff;
  logic [1:0] cmd_q;
  logic [AW-1:0] row_q, col_q;
  logic [AW-1:0] y_q, x_q;
  logic [LW-1:0] next_q, win_q;
  logic [LW-1:0] nb_q [4];
  logic [3:0] absorb_q;
  logic [2:0] abs_cnt_q;
  logic [mcme_pkg::CountW-1:0] count_q;
  logic [2:0] status_q;
  logic open_q;
  logic scan_v_q, scan_rd_done_q;
  logic [AW-1:0] sy_q, sx_q;
  logic [AW-1:0] y_pipe_q, x_pipe_q;
  logic h_in_q, int_q;
  logic pipe_v_q;
  logic scan_pass_last_w;
  logic init_last_w;

  logic [DW-1:0] rowx, colx;
  assign h_eff = (h_reg_q > mcme_pkg::DimW'(MaxDim)) ? DW'(MaxDim) : DW'(h_reg_q);
  assign w_eff = (w_reg_q > mcme_pkg::DimW'(MaxDim)) ? DW'(MaxDim) : DW'(w_reg_q);
  assign rowx = DW'(in_row_i);
  assign colx = DW'(in_col_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_reg_q <= mcme_pkg::DimW'(63);
      w_reg_q <= mcme_pkg::DimW'(63);
      count_q <= '0;
      scan_v_q <= 1'b0;
      scan_rd_done_q <= 1'b0;
    end else begin
      if (cfg_we_i && !cfg_idx_i) h_reg_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i) w_reg_q <= cfg_data_i;
      if (cmd_i.init_step && stat_o.init_last) count_q <= next_q + LW'(1'b1) -
          LW'((y_q[0] && x_q[0]) ? 1'b0 : 1'b1);
      if (cmd_i.write_center)
        count_q <= (count_q > mcme_pkg::CountW'(abs_cnt_q)) ?
                   count_q - mcme_pkg::CountW'(abs_cnt_q) : '0;
      if (cmd_i.scan_start) begin
        scan_v_q <= 1'b1;
        scan_rd_done_q <= 1'b0;
      end else if (cmd_i.scan_step && scan_pass_last_w) begin
        scan_rd_done_q <= 1'b1;
        scan_v_q <= 1'b0;
      end
    end
  end

  assign scan_pass_last_w = scan_v_q && (DW'(sy_q) == h_eff - DW'(1)) &&
                            (DW'(sx_q) == w_eff - DW'(1));

  // memory port
  logic we;
  logic [2*AW-1:0] waddr, raddr;
  logic [LW-1:0] wdata, rdata;
  logic [AW-1:0] nr, nc;

  always_comb begin
    unique case (nb_sel_i)
      2'd0: begin nr = row_q + AW'(1); nc = col_q; end
      2'd1: begin nr = row_q - AW'(1); nc = col_q; end
      2'd2: begin nr = row_q; nc = col_q + AW'(1); end
      default: begin nr = row_q; nc = col_q - AW'(1); end
    endcase
  end

  logic hit;
  assign hit = pipe_v_q && (rdata != Wall) && (
               (absorb_q[0] && rdata == nb_q[0]) || (absorb_q[1] && rdata == nb_q[1]) ||
               (absorb_q[2] && rdata == nb_q[2]) || (absorb_q[3] && rdata == nb_q[3]));

  always_comb begin
    we = 1'b0;
    waddr = {y_q, x_q};
    wdata = (y_q[0] && x_q[0]) ? next_q : Wall;
    raddr = {row_q, col_q};
    if (cmd_i.init_step) we = 1'b1;
    if (cmd_i.rd_nb) raddr = {nr, nc};
    if (cmd_i.scan_step) raddr = {sy_q, sx_q};
    if (pipe_v_q && hit) begin
      we = 1'b1;
      waddr = {y_pipe_q, x_pipe_q};
      wdata = win_q;
    end
    if (cmd_i.write_center) begin
      we = 1'b1;
      waddr = {row_q, col_q};
      wdata = win_q;
    end
  end

  mcme_ram #(.Width(LW), .Depth(MaxDim * MaxDim)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // winner and absorbed set from the four captured neighbors
  logic [LW-1:0] win_c;
  logic [3:0] abs_c;
  logic [2:0] cnt_c;
  always_comb begin
    win_c = Wall;
    abs_c = '0;
    cnt_c = '0;
    for (int i = 0; i < 4; i++) begin
      if (nb_q[i] != Wall) begin
        if (win_c == Wall) win_c = nb_q[i];
        else if (nb_q[i] != win_c) begin
          abs_c[i] = 1'b1;
          for (int k = 0; k < i; k++) if (nb_q[k] == nb_q[i]) abs_c[i] = 1'b0;
          if (abs_c[i]) cnt_c = cnt_c + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pipe_v_q <= 1'b0;
    else pipe_v_q <= cmd_i.scan_step && scan_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q <= in_cmd_i;
      row_q <= AW'(in_row_i);
      col_q <= AW'(in_col_i);
      // note flags held in status path
      h_in_q <= (rowx < h_eff) && (colx < w_eff);
      int_q <= (rowx >= DW'(1)) && (rowx + DW'(2) <= h_eff) &&
               (colx >= DW'(1)) && (colx + DW'(2) <= w_eff) &&
               (h_eff >= DW'(3)) && (w_eff >= DW'(3));
    end
    if (cmd_i.init_start) begin
      y_q <= '0;
      x_q <= '0;
      next_q <= '0;
    end else if (cmd_i.init_step) begin
      if (y_q[0] && x_q[0]) next_q <= next_q + LW'(1);
      if (DW'(x_q) == w_eff - DW'(1)) begin
        x_q <= '0;
        y_q <= y_q + AW'(1);
      end else x_q <= x_q + AW'(1);
    end
    if (cmd_i.cap_nb) begin
      nb_q[0] <= nb_q[1];
      nb_q[1] <= nb_q[2];
      nb_q[2] <= nb_q[3];
      nb_q[3] <= rdata;
    end
    if (cmd_i.decide) begin
      win_q <= win_c;
      absorb_q <= abs_c;
      abs_cnt_q <= cnt_c;
    end
    if (cmd_i.scan_start) begin
      sy_q <= '0;
      sx_q <= '0;
    end else if (cmd_i.scan_step && scan_v_q) begin
      y_pipe_q <= sy_q;
      x_pipe_q <= sx_q;
      if (DW'(sx_q) == w_eff - DW'(1)) begin
        sx_q <= '0;
        sy_q <= sy_q + AW'(1);
      end else sx_q <= sx_q + AW'(1);
    end
    if (cmd_i.set_status) status_q <= cmd_i.status;
    if (cmd_i.set_open) open_q <= 1'b0;
    if (cmd_i.cap_center && cmd_q == mcme_pkg::CMD_READ) open_q <= rdata != Wall;
  end

  // an empty grid ends after one step on the corner wall
  assign init_last_w = (h_eff == '0) || (w_eff == '0) ||
                       ((DW'(y_q) == h_eff - DW'(1)) && (DW'(x_q) == w_eff - DW'(1)));

  always_comb begin
    stat_o.cmd = mcme_pkg::cmd_e'(cmd_q);
    stat_o.interior = int_q;
    stat_o.in_grid = h_in_q;
    stat_o.center_wall = rdata == Wall;
    stat_o.mergeable = cnt_c != 3'd0;
    stat_o.init_last = init_last_w;
    stat_o.scan_last = scan_rd_done_q && !pipe_v_q;
  end

  assign status_o = status_q;
  assign open_o = open_q;
  assign groups_o = count_q;
endmodule

@@ rtl/core/maze_cell_merge_engine_top.sv @@
`timescale 1ns / 1ps
// maze cell merge engine
// input words on s_axis: command, row, column; one result word per input on m_axis
// config: cfg_we_i with cfg_idx_i 0 for grid height, 1 for grid width, written while idle
// init labels the grid one cell per cycle; a merge that finds two or more groups reads
// the center and four neighbors, then relabels in one pass over height*width cells
// words are paced by the single label memory, one cell per cycle
// one word at a time: s_axis_tready is high only when no word is in flight
// the result is held in m_axis_tdata until m_axis_tready takes it
// reset clears the group count and the controller; the label grid holds
// nothing until the first init, sizes reset to 63
module maze_cell_merge_engine_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [6:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // command[1:0], row[7:2], column[13:8]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // status[2:0], cell_open[3], groups_left[14:4]
);
  mcme_pkg::cmd_t cmd;
  mcme_pkg::stat_t stat;
  logic [1:0] nb_sel;
  logic [2:0] status;
  logic open;
  logic [10:0] groups;

  mcme_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .stat_i(stat), .cmd_o(cmd), .nb_sel_o(nb_sel)
  );

  mcme_dp u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_cmd_i(s_axis_tdata[1:0]), .in_row_i(s_axis_tdata[7:2]),
    .in_col_i(s_axis_tdata[13:8]),
    .cmd_i(cmd), .nb_sel_i(nb_sel), .stat_o(stat),
    .status_o(status), .open_o(open), .groups_o(groups)
  );

  assign m_axis_tdata = {1'b0, groups, open, status};
endmodule

@@ bench/tb_maze_cell_merge_engine_top.sv @@
`timescale 1ns / 1ps
module tb_maze_cell_merge_engine_top;

  typedef struct packed {
    mcme_pkg::status_e st;
    logic              open;
    logic [10:0]       grp;
  } result_t;

  typedef struct {
    mcme_pkg::cmd_e cmd;
    logic [5:0]     r;
    logic [5:0]     c;
    bit             typed;
    result_t        res;
  } row_t;

  typedef struct {
    bit      typed;
    result_t res;
  } typed_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [6:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  maze_cell_merge_engine_top uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #100_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // predictor state
  logic [10:0] label_mem [0:4095];
  logic [10:0] groups_m = '0;
  logic [6:0]  height_m = 7'd63;
  logic [6:0]  width_m = 7'd63;

  result_t result_q [$];
  typed_t  typed_q [$];
  int errors = 0;
  int n_words = 0;
  int n_merged = 0;
  int n_results = 0;
  int send_idle = 0;
  int recv_idle = 0;
  bit hold_req = 0;

  task automatic predict_cell_op(input mcme_pkg::cmd_e cmd, input int r, input int c,
                                 output result_t res);
    int h, w, next, absorbed;
    logic [10:0] nb [4];
    logic [10:0] win;
    bit multi, seen;
    h = (height_m > 64) ? 64 : height_m;
    w = (width_m > 64) ? 64 : width_m;
    res.open = 1'b0;
    case (cmd)
      mcme_pkg::CMD_INIT: begin
        next = 0;
        for (int y = 0; y < h; y++)
          for (int x = 0; x < w; x++)
            if (y[0] && x[0]) begin
              label_mem[y*64+x] = next[10:0];
              next++;
            end else begin
              label_mem[y*64+x] = mcme_pkg::WallCode;
            end
        groups_m = next[10:0];
        res.st = mcme_pkg::ST_INIT_DONE;
      end
      mcme_pkg::CMD_MERGE: begin
        if (r < 1 || r + 2 > h || c < 1 || c + 2 > w) begin
          res.st = mcme_pkg::ST_OUTSIDE;
        end else if (label_mem[r*64+c] != mcme_pkg::WallCode) begin
          res.st = mcme_pkg::ST_NO_MERGE;
        end else begin
          nb[0] = label_mem[(r+1)*64+c];
          nb[1] = label_mem[(r-1)*64+c];
          nb[2] = label_mem[r*64+c+1];
          nb[3] = label_mem[r*64+c-1];
          win = mcme_pkg::WallCode;
          multi = 0;
          for (int i = 0; i < 4; i++) begin
            if (nb[i] != mcme_pkg::WallCode) begin
              if (win == mcme_pkg::WallCode) win = nb[i];
              else if (nb[i] != win) multi = 1;
            end
          end
          if (!multi) begin
            res.st = mcme_pkg::ST_NO_MERGE;
          end else begin
            absorbed = 0;
            for (int i = 0; i < 4; i++) begin
              seen = 0;
              for (int k = 0; k < i; k++)
                if (nb[k] == nb[i]) seen = 1;
              if (nb[i] != mcme_pkg::WallCode && nb[i] != win && !seen) begin
                for (int y = 0; y < h; y++)
                  for (int x = 0; x < w; x++)
                    if (label_mem[y*64+x] == nb[i]) label_mem[y*64+x] = win;
                absorbed++;
              end
            end
            label_mem[r*64+c] = win;
            groups_m = (groups_m > absorbed) ? groups_m - absorbed[10:0] : '0;
            res.st = mcme_pkg::ST_MERGED;
          end
        end
      end
      mcme_pkg::CMD_READ: begin
        if (r >= h || c >= w) begin
          res.st = mcme_pkg::ST_OUTSIDE;
        end else begin
          res.st = mcme_pkg::ST_READ_DONE;
          res.open = (label_mem[r*64+c] != mcme_pkg::WallCode);
        end
      end
      default: res.st = mcme_pkg::ST_NO_MERGE;
    endcase
    res.grp = groups_m;
  endtask

  // monitor: prediction at input acceptance, check at output acceptance
  always @(posedge clk_i) begin
    result_t got, want;
    typed_t t;
    if (cfg_we_i) begin
      if (cfg_idx_i) width_m <= cfg_data_i;
      else height_m <= cfg_data_i;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      got.st = mcme_pkg::status_e'(m_axis_tdata[2:0]);
      got.open = m_axis_tdata[3];
      got.grp = m_axis_tdata[14:4];
      n_results++;
      if (got.st == mcme_pkg::ST_MERGED) n_merged++;
      if (result_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word %h", m_axis_tdata);
      end else begin
        want = result_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp st=%0d open=%0d grp=%0d got st=%0d open=%0d grp=%0d",
                     want.st, want.open, want.grp, got.st, got.open, got.grp);
        end
      end
    end
    if (s_axis_tvalid && s_axis_tready) begin
      predict_cell_op(mcme_pkg::cmd_e'(s_axis_tdata[1:0]), int'(s_axis_tdata[7:2]),
                      int'(s_axis_tdata[13:8]), want);
      t = typed_q.pop_front();
      result_q.push_back(t.typed ? t.res : want);
    end
  end

  // receiver
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic send_word(input mcme_pkg::cmd_e cmd, input logic [5:0] r,
                           input logic [5:0] c, input bit typed, input result_t res);
    typed_t t;
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    t.typed = typed;
    t.res = res;
    typed_q.push_back(t);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, c, r, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    n_words++;
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (result_q.size() != 0 || typed_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_size(input logic [6:0] h, input logic [6:0] w);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= 1'b0;
    cfg_data_i <= h;
    @(posedge clk_i);
    cfg_idx_i <= 1'b1;
    cfg_data_i <= w;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  row_t dir [] = '{
    '{mcme_pkg::CMD_INIT,   0,  0, 1, '{mcme_pkg::ST_INIT_DONE, 1'b0, 11'd961}},
    '{mcme_pkg::CMD_READ,   1,  1, 1, '{mcme_pkg::ST_READ_DONE, 1'b1, 11'd961}},
    '{mcme_pkg::CMD_READ,   0,  0, 1, '{mcme_pkg::ST_READ_DONE, 1'b0, 11'd961}},
    '{mcme_pkg::CMD_READ,  62, 62, 1, '{mcme_pkg::ST_READ_DONE, 1'b0, 11'd961}},
    '{mcme_pkg::CMD_READ,  63,  0, 1, '{mcme_pkg::ST_OUTSIDE,   1'b0, 11'd961}},
    '{mcme_pkg::CMD_READ,   0, 63, 1, '{mcme_pkg::ST_OUTSIDE,   1'b0, 11'd961}},
    '{mcme_pkg::CMD_READ,  63, 63, 1, '{mcme_pkg::ST_OUTSIDE,   1'b0, 11'd961}},
    '{mcme_pkg::CMD_MERGE,  0,  5, 1, '{mcme_pkg::ST_OUTSIDE,   1'b0, 11'd961}},
    '{mcme_pkg::CMD_MERGE, 62,  5, 1, '{mcme_pkg::ST_OUTSIDE,   1'b0, 11'd961}},
    '{mcme_pkg::CMD_MERGE,  5, 62, 1, '{mcme_pkg::ST_OUTSIDE,   1'b0, 11'd961}},
    '{mcme_pkg::CMD_MERGE, 63, 63, 1, '{mcme_pkg::ST_OUTSIDE,   1'b0, 11'd961}},
    '{mcme_pkg::CMD_MERGE, 61, 61, 1, '{mcme_pkg::ST_NO_MERGE,  1'b0, 11'd961}},
    '{mcme_pkg::CMD_MERGE,  2,  2, 1, '{mcme_pkg::ST_NO_MERGE,  1'b0, 11'd961}},
    '{mcme_pkg::CMD_MERGE,  1,  2, 1, '{mcme_pkg::ST_MERGED,    1'b0, 11'd960}},
    '{mcme_pkg::CMD_MERGE,  1,  2, 1, '{mcme_pkg::ST_NO_MERGE,  1'b0, 11'd960}},
    '{mcme_pkg::CMD_NONE,  63, 63, 1, '{mcme_pkg::ST_NO_MERGE,  1'b0, 11'd960}},
    '{mcme_pkg::CMD_MERGE,  2,  1, 0, '{mcme_pkg::ST_MERGED,    1'b0, 11'd0}},
    '{mcme_pkg::CMD_MERGE,  2,  3, 0, '{mcme_pkg::ST_MERGED,    1'b0, 11'd0}},
    '{mcme_pkg::CMD_MERGE, 61, 60, 0, '{mcme_pkg::ST_MERGED,    1'b0, 11'd0}},
    '{mcme_pkg::CMD_READ,   1,  2, 0, '{mcme_pkg::ST_MERGED,    1'b0, 11'd0}},
    '{mcme_pkg::CMD_READ,   2,  1, 0, '{mcme_pkg::ST_MERGED,    1'b0, 11'd0}}
  };

  initial begin
    int ph_h [9];
    int ph_w [9];
    int ph_n [9];
    int h, w, r, c, sel;
    result_t none;
    ph_h = '{3, 5, 7, 9, 127, 4, 2, 11, 13};
    ph_w = '{3, 7, 5, 11, 64, 6, 3, 11, 9};
    ph_n = '{6, 15, 15, 20, 4, 8, 5, 20, 17};
    none = '{mcme_pkg::ST_MERGED, 1'b0, 11'd0};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle = 6;
    recv_idle = 52;
    foreach (dir[i]) send_word(dir[i].cmd, dir[i].r, dir[i].c, dir[i].typed, dir[i].res);
    for (int p = 0; p < 9; p++) begin
      drain();
      if (p == 3) begin
        send_idle = 52;
        recv_idle = 6;
      end
      if (p == 6) begin
        send_idle = 0;
        recv_idle = 0;
      end
      set_size(ph_h[p][6:0], ph_w[p][6:0]);
      h = (ph_h[p] > 64) ? 64 : ph_h[p];
      w = (ph_w[p] > 64) ? 64 : ph_w[p];
      send_word(mcme_pkg::CMD_INIT, 6'($urandom_range(63)), 6'($urandom_range(63)),
                1'b0, none);
      if (p == 3) hold_req = 1;
      for (int k = 0; k < ph_n[p]; k++) begin
        sel = $urandom_range(99);
        if (sel < 70 && h >= 3 && w >= 3) begin
          r = $urandom_range(h - 2, 1);
          c = $urandom_range(w - 2, 1);
          if (((r + c) % 2 == 0) && $urandom_range(9) < 8) begin
            if (c + 1 <= w - 2) c++;
            else if (c > 1) c--;
          end
          send_word(mcme_pkg::CMD_MERGE, 6'(r), 6'(c), 1'b0, none);
        end else if (sel < 85) begin
          send_word(mcme_pkg::CMD_READ, 6'($urandom_range(h - 1)),
                    6'($urandom_range(w - 1)), 1'b0, none);
        end else begin
          send_word(mcme_pkg::cmd_e'($urandom_range(3)), 6'($urandom_range(63)),
                    6'($urandom_range(63)), 1'b0, none);
        end
      end
    end
    drain();
    repeat (50) @(posedge clk_i);
    $display("covered %0d words over 10 grid sizes, %0d results, %0d merges",
             n_words, n_results, n_merged);
    if (errors == 0 && result_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/core/mcme_pkg.sv
rtl/core/mcme_ram.sv
rtl/core/mcme_ctrl.sv
rtl/core/mcme_dp.sv
rtl/core/maze_cell_merge_engine_top.sv
bench/tb_maze_cell_merge_engine_top.sv
